/* src/cpba_pkg.sv */
`default_nettype none
package cpba_pkg;

	localparam int unsigned ZONE_PAGES_DEF = 4096;

	localparam int unsigned CMD_W   = 1;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned ALIGN_W = 13;
	localparam int unsigned START_W = 12;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned FREE_W  = 13;

	// cmd travels on tuser, the rest of the request on tdata
	localparam int unsigned IN_BITS  = COUNT_W + ALIGN_W + START_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = STAT_W + START_W + FREE_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FIT    = 2'd1,
		STAT_OUT_ZONE  = 2'd2,
		STAT_RSVD      = 2'd3
	} result_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic scan_step;
		logic mark_step;
		logic free_step;
		logic finish_ok;
		logic finish_fail;
		logic finish_oz;
		logic push;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_free;
		logic alloc_ok;
		logic free_oz;
		logic clr_done;
		logic scan_hit;
		logic scan_end;
		logic mark_done;
		logic free_done;
	} stat_t;

endpackage
`default_nettype wire

/* src/cpba_ctrl.sv */
`default_nettype none
module cpba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           out_fire,
	input  wire cpba_pkg::stat_t st,
	output cpba_pkg::cmd_t      cmd,
	output logic                in_rdy,
	output logic                out_vld
);
	import cpba_pkg::*;

	state_t state_q, state_d;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	// output register: set when a result is pushed, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (cmd.push) out_vld_q <= 1'b1;
		else if (out_fire) out_vld_q <= 1'b0;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_rdy  = 1'b0;
		out_vld = out_vld_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.is_free) begin
					if (st.free_oz) begin
						cmd.finish_oz = 1'b1;
						state_d = ST_DONE;
					end else state_d = ST_FREE;
				end else if (!st.alloc_ok) begin
					cmd.finish_fail = 1'b1;
					state_d = ST_DONE;
				end else if (st.scan_hit) begin
					state_d = ST_MARK;
				end else if (st.scan_end) begin
					cmd.finish_fail = 1'b1;
					state_d = ST_DONE;
				end else cmd.scan_step = 1'b1;
			end
			ST_MARK: begin
				cmd.mark_step = 1'b1;
				if (st.mark_done) begin
					cmd.finish_ok = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_FREE: begin
				cmd.free_step = 1'b1;
				if (st.free_done) begin
					cmd.finish_ok = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (!out_vld_q || out_fire) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE) else $error("word accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && !out_fire |=> out_vld) else $error("result dropped");
	a_mark_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MARK && $past(state_q) != ST_MARK |-> $past(state_q) == ST_SCAN)
		else $error("mark entered oddly");
`endif
endmodule
`default_nettype wire

/* src/cpba_dp.sv */
`default_nettype none
module cpba_dp #(
	parameter int unsigned ZONE_PAGES = cpba_pkg::ZONE_PAGES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cpba_pkg::cmd_t                cmd,
	input  wire logic [cpba_pkg::CMD_W-1:0]    in_cmd,
	input  wire logic [cpba_pkg::COUNT_W-1:0]  in_count,
	input  wire logic [cpba_pkg::ALIGN_W-1:0]  in_align,
	input  wire logic [cpba_pkg::START_W-1:0]  in_start,
	output cpba_pkg::stat_t                    st,
	output logic [cpba_pkg::STAT_W-1:0]        status,
	output logic [cpba_pkg::START_W-1:0]       alloc_start,
	output logic [cpba_pkg::FREE_W-1:0]        pages_free
);
	import cpba_pkg::*;

	localparam int unsigned AW = (ZONE_PAGES > 1) ? $clog2(ZONE_PAGES) : 1;
	localparam int unsigned PW = AW + 1;
	// one spare bit so a candidate start plus an alignment or a count cannot wrap
	localparam int unsigned CW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;

	// one bit per page, a register per page in flip-flops is avoided: memory
	logic mem_q [ZONE_PAGES];
	logic rd_q;

	logic              is_free_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     align_q;
	logic [CW-1:0]     start_q;   // candidate start / free start
	logic [CW-1:0]     ptr_q;     // page being examined
	logic [CW-1:0]     run_q;     // free pages seen from candidate
	logic              skip_q;    // start still stepping past a used page
	logic              rd_vld_q;
	logic [PW-1:0]     clr_q;
	logic [FREE_W-1:0] total_q;
	logic [CW-1:0]     done_q;

	logic [STAT_W-1:0]  res_stat_q;
	logic [START_W-1:0] res_start_q;
	logic [FREE_W-1:0]  res_free_q;

	logic [CW-1:0] zone_c;
	logic [CW-1:0] next_cand, tail;
	logic          wr_en, wr_val;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          rd_en;

	assign zone_c = CW'(ZONE_PAGES);

	// next aligned start after the current candidate
	always_comb begin
		tail      = ptr_q + CW'(1) - start_q;
		next_cand = start_q + align_q;
	end

	assign st.is_free   = is_free_q;
	assign st.alloc_ok  = (count_q != '0) && (count_q <= CW'(total_q));
	assign st.free_oz   = start_q >= zone_c;
	assign st.clr_done  = clr_q == PW'(ZONE_PAGES - 1);
	assign st.scan_hit  = run_q >= count_q;
	assign st.scan_end  = start_q + count_q > zone_c;
	assign st.mark_done = done_q + CW'(1) >= count_q;
	assign st.free_done = (done_q >= count_q) ||
		(start_q + done_q >= zone_c);

	// scan read: one page per step, the read data is registered in rd_q
	assign rd_en   = cmd.scan_step && !rd_vld_q && !skip_q;
	assign rd_addr = ptr_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_val  = 1'b0;
		wr_addr = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
			wr_val = (clr_q == '0);
			wr_addr = clr_q[AW-1:0];
		end else if (cmd.mark_step) begin
			wr_en = 1'b1;
			wr_val = 1'b1;
			wr_addr = AW'(start_q + done_q);
		end else if (cmd.free_step && !st.free_done) begin
			wr_en = 1'b1;
			wr_val = 1'b0;
			wr_addr = AW'(start_q + done_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_val;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			total_q  <= FREE_W'(ZONE_PAGES - 1);
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_step && !st.clr_done) clr_q <= clr_q + PW'(1);
			rd_vld_q <= rd_en;
			if (cmd.finish_ok) begin
				if (is_free_q) begin
					if (CW'(total_q) + count_q > zone_c) total_q <= FREE_W'(ZONE_PAGES);
					else total_q <= FREE_W'(CW'(total_q) + count_q);
				end else total_q <= FREE_W'(CW'(total_q) - count_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q <= (in_cmd == CMD_FREE);
			count_q   <= CW'(in_count);
			align_q   <= (in_align == '0) ? CW'(1) : CW'(in_align);
			start_q   <= (in_cmd == CMD_FREE) ? CW'(in_start) : '0;
			ptr_q     <= '0;
			run_q     <= '0;
			done_q    <= '0;
			skip_q    <= 1'b0;
		end else if (rd_vld_q) begin
			if (rd_q) begin
				// advance the start; keep stepping until it is past the used page
				start_q <= next_cand;
				run_q   <= '0;
				if (next_cand > ptr_q) ptr_q <= next_cand;
				else skip_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + CW'(1);
				run_q <= tail;
			end
		end else if (skip_q && cmd.scan_step) begin
			start_q <= next_cand;
			if (next_cand > ptr_q) begin
				ptr_q  <= next_cand;
				skip_q <= 1'b0;
			end
		end else if (cmd.mark_step || (cmd.free_step && !st.free_done)) begin
			done_q <= done_q + CW'(1);
		end
		if (cmd.finish_ok) begin
			res_stat_q  <= STAT_OK;
			res_start_q <= is_free_q ? '0 : START_W'(start_q);
			res_free_q  <= is_free_q ?
				((CW'(total_q) + count_q > zone_c) ? FREE_W'(ZONE_PAGES)
					: FREE_W'(CW'(total_q) + count_q))
				: FREE_W'(CW'(total_q) - count_q);
		end else if (cmd.finish_fail || cmd.finish_oz) begin
			res_stat_q  <= cmd.finish_oz ? STAT_OUT_ZONE : STAT_NO_FIT;
			res_start_q <= '0;
			res_free_q  <= total_q;
		end
		if (cmd.push) begin
			status      <= res_stat_q;
			alloc_start <= res_start_q;
			pages_free  <= res_free_q;
		end
	end

`ifndef SYNTH
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(total_q) <= zone_c) else $error("free total over zone");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.clr_step, cmd.mark_step, cmd.free_step}) <= 1)
		else $error("two map writers");
	a_mark_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_step |-> start_q + done_q < zone_c)
		else $error("mark past zone");
`endif
endmodule
`default_nettype wire

/* src/contiguous_page_bitmap_allocator.sv */
`default_nettype none
// First-fit contiguous page allocator over a zone of ZONE_PAGES pages kept as a
// one-bit-per-page map in a single-port memory. After reset a clearing pass over
// all ZONE_PAGES pages runs before the first word is taken. One request at a time:
// an allocation scans the map, restarting at the next aligned start past each
// used page (the start steps by the alignment), then marks the pages it found;
// a free clears its pages one by one. The map memory port handles one page at a
// time. A finished result waits in an output register, so the next request is
// taken while the last word is held.
module contiguous_page_bitmap_allocator #(
	parameter int unsigned ZONE_PAGES = cpba_pkg::ZONE_PAGES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// cmd
	input  wire logic [cpba_pkg::CMD_W-1:0]  s_tuser,
	// page_count, align_pages, start_page
	input  wire logic [cpba_pkg::IN_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// status, alloc_start, free page count
	output logic [cpba_pkg::OUT_W-1:0]       m_tdata
);
	import cpba_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic [STAT_W-1:0]  status;
	logic [START_W-1:0] alloc_start;
	logic [FREE_W-1:0]  pages_free;

	cpba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready),
		.st(st), .cmd(cmd), .in_rdy(s_tready), .out_vld(m_tvalid)
	);

	cpba_dp #(.ZONE_PAGES(ZONE_PAGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_cmd(s_tuser),
		.in_count(s_tdata[COUNT_W-1:0]),
		.in_align(s_tdata[COUNT_W+ALIGN_W-1:COUNT_W]),
		.in_start(s_tdata[IN_BITS-1:COUNT_W+ALIGN_W]),
		.st(st), .status(status), .alloc_start(alloc_start),
		.pages_free(pages_free)
	);

	assign m_tdata = {{(OUT_W-OUT_BITS){1'b0}}, pages_free, alloc_start, status};
endmodule
`default_nettype wire
